// ----- src/bilateral_window_filter_defines.svh -----
// assertion macros used by the checker file
`ifndef BILATERAL_WINDOW_FILTER_DEFINES_SVH
`define BILATERAL_WINDOW_FILTER_DEFINES_SVH

// consequent must hold in the cycle after the antecedent, outside reset
`define BWF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bwf check failed");

// consequent must hold in the cycle after reset is high
`define BWF_ASSERT_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("bwf reset check failed");

`endif

// ----- src/bwf_pkg.sv -----
// types and fixed constants of the bilateral window filter
package bwf_pkg;

  localparam int ROW_W = 12;
  localparam int HGT_W = 13;
  localparam int CFG_WIDTH_W = 12;
  localparam int CNT_W = 23;
  localparam int PADDR_W = 3;

  localparam logic [CFG_WIDTH_W-1:0] RST_IMAGE_WIDTH = 12'd640;
  localparam logic [HGT_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [HGT_W-1:0] MAX_HEIGHT = 13'd4096;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_FLUSH = 2'd1,
    REQ_RANGE = 2'd2,
    REQ_SPACE = 2'd3
  } req_code_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_TAPS,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ----- src/bwf_req_if.sv -----
// request channel: pixels, flush ticks and weight writes
interface bwf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  pix_b;
  logic [7:0]  pix_g;
  logic [7:0]  pix_r;
  logic [7:0]  table_index;
  logic [15:0] table_weight;

  modport source (output valid, req_type, pix_b, pix_g, pix_r, table_index, table_weight,
                  input ready);
  modport sink (input valid, req_type, pix_b, pix_g, pix_r, table_index, table_weight,
                output ready);
endinterface

// ----- src/bwf_res_if.sv -----
// result channel: filtered pixels
interface bwf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_b;
  logic [7:0] out_g;
  logic [7:0] out_r;
  logic       frame_end;

  modport source (output valid, out_b, out_g, out_r, frame_end, input ready);
  modport sink (input valid, out_b, out_g, out_r, frame_end, output ready);
endinterface

// ----- src/bwf_div.sv -----
// restoring divider: rounded weighted mean of one channel, 8 quotient bits
module bwf_div import bwf_pkg::*; #(
  parameter int DEN_W = 37
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DEN_W+7:0]   num,
  input  logic [DEN_W-1:0]   den,
  input  logic [7:0]         centre,
  output logic               done,
  output logic [7:0]         q
);

  localparam int N_W = DEN_W + 9;
  localparam int DS_W = DEN_W + 8;

  logic [N_W-1:0]  rem;
  logic [DS_W-1:0] dsh;
  logic [2:0]      cnt;
  logic            busy;
  logic            fits;
  logic            zden;

  assign fits = rem >= N_W'(dsh);

  // control: always a full 8-step run so every channel finishes together
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 3'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: (2*num + den) / (2*den), quotient known to fit 8 bits
  // a zero weight sum keeps the centre value
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= N_W'({num, 1'b0}) + N_W'(den);
      dsh  <= DS_W'(den) << 8;
      cnt  <= 3'd7;
      zden <= (den == '0);
      q    <= (den == '0) ? centre : 8'd0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - N_W'(dsh);
      end
      if (!zden) begin
        q <= {q[6:0], fits};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - 3'd1;
    end
  end

endmodule

// ----- src/bilateral_window_filter.sv -----
// top level of the bilateral window filter
//
// Usage: frames arrive in raster order on req as pixel beats (req_type pixel);
// range and space weight tables (Q1.15) are loaded with weight beats before
// use. Each pixel beat once the window lag (half rows plus half pixels) is
// reached gives one filtered pixel beat on res; after the last pixel of a
// frame, flush beats drain the remaining outputs one each. frame_end marks
// the last output pixel of a frame.
// image_width and image_height are set over the APB port while idle; a write
// restarts the frame.
// Throughput: one item at a time. A beat with no result leaves the block
// idle. A beat that yields a pixel passes a centre read, one line store
// read per tap through a single read port, the tap pipeline drain, an
// 8-step divider and its done pulse, the output load, which puts the pixel
// on res, and the return to idle.
// Reset clears the frame counters, the state machine and the output valid; the
// weight tables and line store hold nothing valid until written.
// When res stalls, a finished pixel waits in the output register and the
// block waits before loading the next one.
module bilateral_window_filter import bwf_pkg::*; #(
  parameter int WINDOW = 5,
  parameter int MAX_WIDTH = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  bwf_req_if.sink            req,
  bwf_res_if.source          res
);

  localparam int HALF = (WINDOW - 1) / 2;
  localparam int TAPS = WINDOW * WINDOW;
  localparam int TAP_W = $clog2(TAPS);
  localparam int WIN_W = $clog2(WINDOW);
  localparam int DEPTH = WINDOW * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int PROD_W = 2 * WEIGHT_BITS;
  localparam int DEN_W = PROD_W + $clog2(TAPS + 1);
  localparam int NUM_W = DEN_W + 8;

  // configuration and frame counters
  logic [CFG_WIDTH_W-1:0] image_width;
  logic [HGT_W-1:0]       image_height;
  logic [WID_W-1:0]       eff_w;
  logic [HGT_W-1:0]       eff_h;
  logic [COL_W-1:0]       in_col, out_col, base_col;
  logic [ROW_W-1:0]       in_row, out_row, base_row;
  logic [WIN_W-1:0]       in_slot, out_slot, base_slot;
  logic [CNT_W-1:0]       in_cnt, base_cnt, lag;
  logic                   frame_full;
  logic                   cfg_we;

  // control
  state_t state, state_next;
  logic   accept, emit_pix, start_filter, issue, pipe_empty, div_start, load;
  logic   cap_centre;
  logic   v1, v2, v3;
  logic   out_last;
  logic [2:0] div_done;

  // tap sequencer
  logic [WIN_W-1:0] ty, tx;
  logic [TAP_W-1:0] tk;
  logic [ROW_W:0]   sum_r, rr;
  logic [COL_W+1:0] sum_c, cc;
  logic [WIN_W-1:0] dr;
  logic [WIN_W+1:0] slot_t;
  logic [WIN_W-1:0] tap_slot;
  logic [ADDR_W-1:0] rd_addr, wr_addr;

  // memories
  logic [23:0]            line_mem [DEPTH];
  logic [23:0]            line_rd;
  logic [WEIGHT_BITS-1:0] space_mem [TAPS];
  logic [WEIGHT_BITS-1:0] space_rd;
  logic [WEIGHT_BITS-1:0] weight_in;

  // per-channel datapath
  logic [7:0]             centre [3];
  logic [7:0]             tap1 [3];
  logic [7:0]             tap2 [3];
  logic [7:0]             diff [3];
  logic [WEIGHT_BITS-1:0] sw1;
  logic [WEIGHT_BITS-1:0] rng_rd [3];
  logic [PROD_W-1:0]      wt2 [3];
  logic [NUM_W-1:0]       num_acc [3];
  logic [DEN_W-1:0]       den_acc [3];
  logic [7:0]             q [3];

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign weight_in = WEIGHT_BITS'(req.table_weight);

  // register read
  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = 32'd0;
    endcase
  end

  // effective frame size
  always_comb begin
    if (image_width == '0) begin
      eff_w = WID_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HGT_W'(1);
    end else if (image_height > MAX_HEIGHT) begin
      eff_h = MAX_HEIGHT;
    end else begin
      eff_h = image_height;
    end
  end

  // input position, restarted when a full frame is followed by a pixel
  always_comb begin
    base_col  = frame_full ? '0 : in_col;
    base_row  = frame_full ? '0 : in_row;
    base_slot = frame_full ? '0 : in_slot;
    base_cnt  = frame_full ? '0 : in_cnt;
    lag       = CNT_W'(HALF) * CNT_W'(eff_w) + CNT_W'(HALF);
    emit_pix  = base_cnt >= lag;
    wr_addr   = ADDR_W'(base_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(base_col);
    out_last  = (out_row == ROW_W'(eff_h - HGT_W'(1))) &&
                (out_col == COL_W'(eff_w - WID_W'(1)));
  end

  assign accept = req.valid && req.ready;
  assign start_filter = (req_code_t'(req.req_type) == REQ_PIXEL && emit_pix) ||
                        (req_code_t'(req.req_type) == REQ_FLUSH && frame_full);
  assign pipe_empty = !(v1 || v2 || v3);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req.valid && start_filter) state_next = ST_CENTRE;
      ST_CENTRE: state_next = ST_TAPS;
      ST_TAPS:   if (tk == TAP_W'(TAPS - 1)) state_next = ST_DRAIN;
      ST_DRAIN:  if (pipe_empty) state_next = ST_DIV;
      ST_DIV:    if (div_done == 3'b111) state_next = ST_OUT;
      ST_OUT:    if (!res.valid || res.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready = (state == ST_IDLE);
    issue     = (state == ST_TAPS);
    div_start = (state == ST_DRAIN) && pipe_empty;
    load      = (state == ST_OUT) && (!res.valid || res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      in_col <= '0; in_row <= '0; in_slot <= '0; in_cnt <= '0;
      out_col <= '0; out_row <= '0; out_slot <= '0;
      frame_full <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(paddr[2]))
        REG_IMAGE_WIDTH:  image_width <= pwdata[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HGT_W-1:0];
        default: ;
      endcase
      in_col <= '0; in_row <= '0; in_slot <= '0; in_cnt <= '0;
      out_col <= '0; out_row <= '0; out_slot <= '0;
      frame_full <= 1'b0;
    end else if (accept && req_code_t'(req.req_type) == REQ_PIXEL) begin
      in_cnt <= base_cnt + CNT_W'(1);
      frame_full <= 1'b0;
      if ((COL_W+1)'(base_col) + (COL_W+1)'(1) >= (COL_W+1)'(eff_w)) begin
        in_col <= '0;
        if ((ROW_W+1)'(base_row) + (ROW_W+1)'(1) >= eff_h) begin
          in_row <= '0;
          in_slot <= '0;
          frame_full <= 1'b1;
        end else begin
          in_row <= base_row + ROW_W'(1);
          in_slot <= (base_slot == WIN_W'(WINDOW - 1)) ? '0 : base_slot + WIN_W'(1);
        end
      end else begin
        in_col <= base_col + COL_W'(1);
        in_row <= base_row;
        in_slot <= base_slot;
      end
      if (frame_full) begin
        out_col <= '0; out_row <= '0; out_slot <= '0;
      end
    end else if (load) begin
      if (out_last) begin
        in_col <= '0; in_row <= '0; in_slot <= '0; in_cnt <= '0;
        out_col <= '0; out_row <= '0; out_slot <= '0;
        frame_full <= 1'b0;
      end else if (out_col == COL_W'(eff_w - WID_W'(1))) begin
        out_col <= '0;
        out_row <= out_row + ROW_W'(1);
        out_slot <= (out_slot == WIN_W'(WINDOW - 1)) ? '0 : out_slot + WIN_W'(1);
      end else begin
        out_col <= out_col + COL_W'(1);
      end
    end
  end

  // tap address: clamp to the frame, map the row to its line slot
  always_comb begin
    sum_r = (ROW_W+1)'(out_row) + (ROW_W+1)'(ty);
    rr = (sum_r < (ROW_W+1)'(HALF)) ? '0 : sum_r - (ROW_W+1)'(HALF);
    if (rr > (ROW_W+1)'(eff_h - HGT_W'(1))) begin
      rr = (ROW_W+1)'(eff_h - HGT_W'(1));
    end
    dr = WIN_W'(rr + (ROW_W+1)'(HALF) - (ROW_W+1)'(out_row));
    slot_t = (WIN_W+2)'(out_slot) + (WIN_W+2)'(dr) + (WIN_W+2)'(WINDOW - HALF);
    if (slot_t >= (WIN_W+2)'(2 * WINDOW)) begin
      slot_t = slot_t - (WIN_W+2)'(2 * WINDOW);
    end else if (slot_t >= (WIN_W+2)'(WINDOW)) begin
      slot_t = slot_t - (WIN_W+2)'(WINDOW);
    end
    tap_slot = WIN_W'(slot_t);
    sum_c = (COL_W+2)'(out_col) + (COL_W+2)'(tx);
    cc = (sum_c < (COL_W+2)'(HALF)) ? '0 : sum_c - (COL_W+2)'(HALF);
    if (cc > (COL_W+2)'(eff_w - WID_W'(1))) begin
      cc = (COL_W+2)'(eff_w - WID_W'(1));
    end
    if (issue) begin
      rd_addr = ADDR_W'(tap_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cc);
    end else begin
      rd_addr = ADDR_W'(out_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(out_col);
    end
  end

  // tap counters
  always_ff @(posedge clk) begin
    if (state == ST_CENTRE) begin
      ty <= '0; tx <= '0; tk <= '0;
    end else if (issue) begin
      tk <= tk + TAP_W'(1);
      if (tx == WIN_W'(WINDOW - 1)) begin
        tx <= '0;
        ty <= ty + WIN_W'(1);
      end else begin
        tx <= tx + WIN_W'(1);
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; cap_centre <= 1'b0;
    end else begin
      v1 <= issue; v2 <= v1; v3 <= v2;
      cap_centre <= (state == ST_CENTRE);
    end
  end

  // line store: pixel write, one read per cycle
  always_ff @(posedge clk) begin
    if (accept && req_code_t'(req.req_type) == REQ_PIXEL) begin
      line_mem[wr_addr] <= {req.pix_r, req.pix_g, req.pix_b};
    end
    line_rd <= line_mem[rd_addr];
  end

  // space weights
  always_ff @(posedge clk) begin
    if (accept && req_code_t'(req.req_type) == REQ_SPACE && 32'(req.table_index) < TAPS) begin
      space_mem[TAP_W'(req.table_index)] <= weight_in;
    end
    space_rd <= space_mem[tk];
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      sw1 <= space_rd;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [WEIGHT_BITS-1:0] rng_mem [256];

    // range weights, one copy per channel
    always_ff @(posedge clk) begin
      if (accept && req_code_t'(req.req_type) == REQ_RANGE) begin
        rng_mem[req.table_index] <= weight_in;
      end
      rng_rd[ch] <= rng_mem[diff[ch]];
    end

    always_comb begin
      if (line_rd[8*ch +: 8] > centre[ch]) begin
        diff[ch] = line_rd[8*ch +: 8] - centre[ch];
      end else begin
        diff[ch] = centre[ch] - line_rd[8*ch +: 8];
      end
    end

    // tap stages: difference, weight product, accumulate
    always_ff @(posedge clk) begin
      if (cap_centre) begin
        centre[ch] <= line_rd[8*ch +: 8];
      end
      if (v1) begin
        tap1[ch] <= line_rd[8*ch +: 8];
      end
      if (v2) begin
        wt2[ch]  <= PROD_W'(sw1) * PROD_W'(rng_rd[ch]);
        tap2[ch] <= tap1[ch];
      end
      if (state == ST_CENTRE) begin
        num_acc[ch] <= '0;
        den_acc[ch] <= '0;
      end else if (v3) begin
        num_acc[ch] <= num_acc[ch] + NUM_W'((PROD_W+8)'(wt2[ch]) * (PROD_W+8)'(tap2[ch]));
        den_acc[ch] <= den_acc[ch] + DEN_W'(wt2[ch]);
      end
    end

    bwf_div #(.DEN_W(DEN_W)) u_div (
      .clk    (clk),
      .rst    (rst),
      .start  (div_start),
      .num    (num_acc[ch]),
      .den    (den_acc[ch]),
      .centre (centre[ch]),
      .done   (div_done[ch]),
      .q      (q[ch])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.out_b     <= q[0];
      res.out_g     <= q[1];
      res.out_r     <= q[2];
      res.frame_end <= out_last;
    end
  end

endmodule

// ----- src/bwf_checker.sv -----
// port-level checks of the bilateral window filter, bound to the top level
`include "bilateral_window_filter_defines.svh"

module bwf_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_b,
  input logic [7:0] res_g,
  input logic [7:0] res_r,
  input logic       res_end
);

  // a result never shows up right after a beat taken with the output empty
  `BWF_ASSERT_NEXT(a_no_early_result, clk, rst, req_valid && req_ready && !res_valid, !res_valid)

  // a stalled result holds
  `BWF_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable({res_b, res_g, res_r, res_end}))

  // reset leaves the block ready with nothing pending
  `BWF_ASSERT_RESET(a_reset_state, clk, rst, req_ready && !res_valid)

endmodule

bind bilateral_window_filter bwf_checker u_bwf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_b     (res.out_b),
  .res_g     (res.out_g),
  .res_r     (res.out_r),
  .res_end   (res.frame_end)
);
